// File: hdl/shc_pkg.sv
// ----------------------------------------------------------------------------
// shc_pkg: shared types and constants of the sawtooth chain row generator
// Chain size, bond count, field widths, accumulator sizing, register indexes
// and the bond record that travels along the row of cells.
// ----------------------------------------------------------------------------
package shc_pkg;

   // Chain geometry
   localparam int CHAIN_SITES = 16;
   localparam int TRIANGLES   = CHAIN_SITES / 2;
   localparam int BOND_COUNT  = 3 * TRIANGLES;

   // Field widths
   localparam int ROW_W       = 16;
   localparam int COUPLING_W  = 16;
   localparam int ENTRY_W     = 21;
   localparam int CSR_INDEX_W = 1;

   // Spin word: at least as wide as the chain, sites above the row word read as down
   localparam int SITE_W = (CHAIN_SITES > ROW_W) ? CHAIN_SITES : ROW_W;

   // Diagonal accumulator: room for BOND_COUNT terms of full-scale coupling
   localparam int ACC_NEED = COUPLING_W + $clog2(BOND_COUNT) + 1;
   localparam int ACC_W    = (ACC_NEED > ENTRY_W + 1) ? ACC_NEED : ENTRY_W + 1;

   // Bond countdown
   localparam int REM_W = $clog2(BOND_COUNT + 1);

   // Saturation bounds of an entry, at accumulator width
   localparam logic signed [ACC_W-1:0] ENTRY_MAX_ACC = ACC_W'(1048575);
   localparam logic signed [ACC_W-1:0] ENTRY_MIN_ACC = ACC_W'(-1048576);

   // Coupling reset: 1.0 in Q8.8
   localparam logic signed [COUPLING_W-1:0] COUPLING_RESET = 16'sd256;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COUPLING_J1 = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUPLING_J2 = 1'b1;

   // One bond as held by a cell
   typedef struct packed {
      logic             anti;    // spins antiparallel: emits an entry
      logic [ROW_W-1:0] column;  // row with both bond spins flipped
      logic             use_j2;  // side bond (J2) rather than base bond (J1)
   } bond_type;

endpackage

// File: hdl/shc_cell.sv
// ----------------------------------------------------------------------------
// shc_cell: one bond cell of the shift chain
// Evaluates its bond for a newly loaded row, then hands the bond record to
// its left neighbor on every advance of the chain.
// ----------------------------------------------------------------------------
module shc_cell
   import shc_pkg::*;
(
   input  logic             clock,
   input  logic             load,
   input  logic             shift,
   input  logic [ROW_W-1:0] load_row,
   input  logic [ROW_W-1:0] flip_mask,
   input  logic             spin_a,
   input  logic             spin_b,
   input  logic             use_j2,
   input  bond_type         next_bond,
   output bond_type         bond
);

   bond_type bond_ff;
   bond_type bond_in;
   bond_type fresh;

   // Evaluate the bond for the row being loaded
   always_comb begin
      fresh.anti   = spin_a ^ spin_b;
      fresh.column = load_row ^ flip_mask;
      fresh.use_j2 = use_j2;
   end

   // Load, take the neighbor's bond, or hold
   always_comb begin
      if (load) begin
         bond_in = fresh;
      end else if (shift) begin
         bond_in = next_bond;
      end else begin
         bond_in = bond_ff;
      end
   end

   always_ff @(posedge clock) begin
      bond_ff <= bond_in;
   end

   assign bond = bond_ff;

endmodule

// File: hdl/shc_emit.sv
// ----------------------------------------------------------------------------
// shc_emit: head of the chain, diagonal accumulator and result register
// Consumes one bond per cycle from the head cell unless a stalled result blocks it,
// emits off-diagonal items for antiparallel bonds, and closes each row with the saturated diagonal.
// ----------------------------------------------------------------------------
module shc_emit
   import shc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COUPLING_W-1:0]  coupling_j1,
   input  logic signed [COUPLING_W-1:0]  coupling_j2,
   input  logic                          buf_valid,
   input  logic [ROW_W-1:0]              buf_row,
   input  bond_type                      head,
   output logic                          load,
   output logic                          shift,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ROW_W-1:0]              rsp_column_index,
   output logic signed [ENTRY_W-1:0]     rsp_entry_value,
   output logic                          rsp_is_diagonal,
   output logic                          rsp_last_of_row
);

   logic                         busy_ff, busy_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic                         out_valid_ff, out_valid_in;
   logic [ROW_W-1:0]             out_col_ff, out_col_in;
   logic signed [ENTRY_W-1:0]    out_val_ff, out_val_in;
   logic                         out_diag_ff, out_diag_in;

   logic                         bond_phase;
   logic                         diag_phase;
   logic                         need_out;
   logic                         out_free;
   logic                         step;
   logic signed [COUPLING_W-1:0] j_sel;
   logic signed [ACC_W-1:0]      j_ext;
   logic signed [ACC_W-1:0]      acc_sat;

   // Sequence: bonds first, then one diagonal step
   assign bond_phase = busy_ff && (rem_ff != '0);
   assign diag_phase = busy_ff && (rem_ff == '0);
   assign need_out   = (bond_phase && head.anti) || diag_phase;
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign step       = busy_ff && (!need_out || out_free);
   assign shift      = step && bond_phase;
   assign load       = buf_valid && (!busy_ff || (step && diag_phase));

   // Pick the coupling of the head bond
   assign j_sel = head.use_j2 ? coupling_j2 : coupling_j1;
   assign j_ext = ACC_W'(j_sel);

   // Clamp the diagonal to the entry range
   always_comb begin
      if (acc_ff > ENTRY_MAX_ACC) begin
         acc_sat = ENTRY_MAX_ACC;
      end else if (acc_ff < ENTRY_MIN_ACC) begin
         acc_sat = ENTRY_MIN_ACC;
      end else begin
         acc_sat = acc_ff;
      end
   end

   // Next state of the row walk
   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      row_in  = row_ff;
      if (load) begin
         busy_in = 1'b1;
         rem_in  = REM_W'(BOND_COUNT);
         acc_in  = '0;
         row_in  = buf_row;
      end else begin
         if (shift) begin
            rem_in = rem_ff - 1'b1;
            acc_in = head.anti ? (acc_ff - j_ext) : (acc_ff + j_ext);
         end
         if (step && diag_phase) begin
            busy_in = 1'b0;
         end
      end
   end

   // Result register: fill on an emitting step, drop once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_col_in   = out_col_ff;
      out_val_in   = out_val_ff;
      out_diag_in  = out_diag_ff;
      if (step && need_out) begin
         out_valid_in = 1'b1;
         if (diag_phase) begin
            out_col_in  = row_ff;
            out_val_in  = acc_sat[ENTRY_W-1:0];
            out_diag_in = 1'b1;
         end else begin
            out_col_in  = head.column;
            out_val_in  = {{(ENTRY_W-COUPLING_W-1){j_sel[COUPLING_W-1]}}, j_sel, 1'b0};
            out_diag_in = 1'b0;
         end
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
      acc_ff      <= acc_in;
      row_ff      <= row_in;
      out_col_ff  <= out_col_in;
      out_val_ff  <= out_val_in;
      out_diag_ff <= out_diag_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_column_index = out_col_ff;
   assign rsp_entry_value  = out_val_ff;
   assign rsp_is_diagonal  = out_diag_ff;
   assign rsp_last_of_row  = out_diag_ff;

   // Chain advances only while bonds remain
   a_shift_needs_bond: assert property (@(posedge clock) disable iff (reset)
      shift |-> (rem_ff != '0))
      else $error("chain advanced with no bond left");

   // Idle walk has no bonds pending
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (rem_ff == '0))
      else $error("bonds pending while idle");

   // A load starts a full walk
   a_load_full: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && (rem_ff == REM_W'(BOND_COUNT))))
      else $error("load did not start a full row");

   // Countdown stays within the bond count
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= REM_W'(BOND_COUNT))
      else $error("bond countdown out of range");

endmodule

// File: hdl/spin_chain_hamiltonian_row_top.sv
// Each accepted item is a basis state; the block returns its row of the
// periodic sawtooth-chain Heisenberg Hamiltonian as one result item per
// antiparallel bond (column with both spins flipped, value 2*J in 1/256
// units), in triangle order base, left side, right side, followed by the
// saturated diagonal flagged is_diagonal and last_of_row. A row occupies
// the bond chain while the emitter retires one bond of the cell chain per
// cycle and then the diagonal; stalls on the result side hold the chain.
// The next item waits in a one-deep input buffer and enters the chain in
// the cycle the diagonal leaves, so rows follow without gaps. Couplings are
// to be written by the user through the csr port only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// spin_chain_hamiltonian_row_top: sawtooth chain Hamiltonian row generator
// Input buffer, coupling registers, a chain of one cell per bond, and the
// emitter that serializes the row onto the result channel.
// ----------------------------------------------------------------------------
module spin_chain_hamiltonian_row_top
   import shc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [COUPLING_W-1:0]     csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ROW_W-1:0]          req_basis_state,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ROW_W-1:0]          rsp_column_index,
   output logic signed [ENTRY_W-1:0] rsp_entry_value,
   output logic                      rsp_is_diagonal,
   output logic                      rsp_last_of_row
);

   logic signed [COUPLING_W-1:0] j1_ff, j1_in;
   logic signed [COUPLING_W-1:0] j2_ff, j2_in;
   logic                         buf_valid_ff, buf_valid_in;
   logic [ROW_W-1:0]             buf_row_ff, buf_row_in;
   logic                         req_accept;
   logic                         load;
   logic                         shift;
   logic [SITE_W-1:0]            spins;
   bond_type                     cell_bond [BOND_COUNT];

   // Coupling registers
   always_comb begin
      j1_in = j1_ff;
      j2_in = j2_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_COUPLING_J1: j1_in = csr_data;
            CSR_COUPLING_J2: j2_in = csr_data;
            default: begin
               j1_in = j1_ff;
               j2_in = j2_ff;
            end
         endcase
      end
   end

   // Input buffer: take an item when empty or when it moves into the chain
   assign req_stall  = buf_valid_ff && !load;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_row_in   = buf_row_ff;
      if (req_accept) begin
         buf_valid_in = 1'b1;
         buf_row_in   = req_basis_state;
      end else if (load) begin
         buf_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j1_ff        <= COUPLING_RESET;
         j2_ff        <= COUPLING_RESET;
         buf_valid_ff <= 1'b0;
      end else begin
         j1_ff        <= j1_in;
         j2_ff        <= j2_in;
         buf_valid_ff <= buf_valid_in;
      end
      buf_row_ff <= buf_row_in;
   end

   // Sites beyond the row word read as spin down
   assign spins = SITE_W'(buf_row_ff);

   // One cell per bond, head at index zero
   for (genvar k = 0; k < BOND_COUNT; k++) begin : g_cell
      localparam int TRI    = k / 3;
      localparam int KIND   = k % 3;
      localparam int SITE_L = (2 * TRI) % CHAIN_SITES;
      localparam int SITE_M = (2 * TRI + 1) % CHAIN_SITES;
      localparam int SITE_R = (2 * TRI + 2) % CHAIN_SITES;
      localparam int SA     = (KIND == 2) ? SITE_M : SITE_L;
      localparam int SB     = (KIND == 1) ? SITE_M : SITE_R;
      localparam logic [SITE_W-1:0] FLIP = (SITE_W'(1) << SA) | (SITE_W'(1) << SB);

      bond_type next_bond;

      if (k == BOND_COUNT - 1) begin : g_tail
         assign next_bond = '0;
      end else begin : g_link
         assign next_bond = cell_bond[k+1];
      end

      shc_cell u_cell (
         .clock     (clock),
         .load      (load),
         .shift     (shift),
         .load_row  (buf_row_ff),
         .flip_mask (FLIP[ROW_W-1:0]),
         .spin_a    (spins[SA]),
         .spin_b    (spins[SB]),
         .use_j2    (KIND != 0),
         .next_bond (next_bond),
         .bond      (cell_bond[k])
      );
   end

   // Serialize the row
   shc_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .coupling_j1      (j1_ff),
      .coupling_j2      (j2_ff),
      .buf_valid        (buf_valid_ff),
      .buf_row          (buf_row_ff),
      .head             (cell_bond[0]),
      .load             (load),
      .shift            (shift),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_index (rsp_column_index),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_is_diagonal  (rsp_is_diagonal),
      .rsp_last_of_row  (rsp_last_of_row)
   );

endmodule
